/* src/gcc_pkg.sv */
// Shared types and constants for the graph connectivity checker.
// No dependencies; every other file in src uses this package.
package gcc_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [NODE_W:0]    NODE_LIMIT = (NODE_W+1)'(MAX_NODES);

  // Control sequencer codes.
  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_DRAIN  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;

  // Word that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic               edge_ok;  // carries an edge with both ends in range
    logic               mark;     // end-of-graph marker
    logic               seeded;   // a search seed has already been placed
    logic [COUNT_W-1:0] count;    // present nodes seen so far by the marker
  } chain_word_t;

  // Per-cell flags reported to the controller.
  typedef struct packed {
    logic present;
    logic visited;
    logic frontier;
  } cell_stat_t;

endpackage

/* src/gcc_if.sv */
// Valid/ready channel interfaces for the graph connectivity checker.
// Depends on gcc_pkg for field widths.
interface gcc_edge_if;
  logic                      valid;
  logic                      ready;
  logic [gcc_pkg::NODE_W-1:0] node_a;
  logic [gcc_pkg::NODE_W-1:0] node_b;
  logic                      edge_valid;
  logic                      last_item;

  modport source(output valid, node_a, node_b, edge_valid, last_item, input ready);
  modport sink(input valid, node_a, node_b, edge_valid, last_item, output ready);
endinterface

interface gcc_result_if;
  logic                       valid;
  logic                       ready;
  logic                       connected;
  logic [gcc_pkg::COUNT_W-1:0] node_count;

  modport source(output valid, connected, node_count, input ready);
  modport sink(input valid, connected, node_count, output ready);
endinterface

/* src/graph_connectivity_check.sv */
// Top level of the graph connectivity checker: row of node cells plus control.
// Depends on gcc_pkg, gcc_if (gcc_edge_if, gcc_result_if) and gcc_cell.
// Usage:
//   edges  - sink channel, one word per edge: node_a, node_b, edge_valid,
//            last_item. Words are taken one per cycle while a graph loads.
//            A word with last_item set closes the graph; it may carry an edge.
//   result - source channel, one word per closed graph: connected and
//            node_count (distinct nodes seen in edges, 1 for an empty graph's
//            connected flag with a count of zero).
// Timing:
//   Edge words enter a row of MAX_NODES cells and move one cell per cycle;
//   each cell stores its own adjacency row. After the last word is taken,
//   the input is held off while that word walks the row (placing the search
//   seed at the lowest present node and counting nodes), then one frontier
//   expansion runs per cycle until the frontier is empty. Once the result
//   register is free, the answer is registered and the whole graph is
//   cleared in the same cycle; loading resumes next cycle.
// Reset and stall:
//   rst clears every cell, the sequencer and the result valid flag. A stalled
//   result word holds in its register while the next graph loads; only the
//   following answer waits until the receiver takes it.
module graph_connectivity_check (
  input logic               clk,
  input logic               rst,
  gcc_edge_if.sink          edges,
  gcc_result_if.source      result
);

  gcc_pkg::chain_word_t chain [0:gcc_pkg::MAX_NODES];
  gcc_pkg::cell_stat_t  stat  [0:gcc_pkg::MAX_NODES-1];

  logic [gcc_pkg::MAX_NODES-1:0] present_v;
  logic [gcc_pkg::MAX_NODES-1:0] visited_v;
  logic [gcc_pkg::MAX_NODES-1:0] frontier_v;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [gcc_pkg::COUNT_W-1:0] count;

  logic accept;
  logic marker_out;
  logic search_en;
  logic done;
  logic in_range;

  // Accept edge words only while a graph is loading.
  assign edges.ready = (state == gcc_pkg::ST_LOAD);
  assign accept      = edges.valid && edges.ready;

  // Drop the edge if either end lies outside the node range.
  assign in_range = ({1'b0, edges.node_a} < gcc_pkg::NODE_LIMIT) &&
                    ({1'b0, edges.node_b} < gcc_pkg::NODE_LIMIT);

  always_comb begin
    chain[0].valid   = accept;
    chain[0].node_a  = edges.node_a;
    chain[0].node_b  = edges.node_b;
    chain[0].edge_ok = edges.edge_valid && in_range;
    chain[0].mark    = edges.last_item;
    chain[0].seeded  = 1'b0;
    chain[0].count   = '0;
  end

  // Row of node cells; the frontier vector is broadcast back to every cell.
  for (genvar k = 0; k < gcc_pkg::MAX_NODES; k++) begin : g_cell
    gcc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .idx          (gcc_pkg::NODE_W'(k)),
      .word_in      (chain[k]),
      .word_out     (chain[k+1]),
      .frontier_bus (frontier_v),
      .search_en    (search_en),
      .clear        (done),
      .stat         (stat[k])
    );
    assign present_v[k]  = stat[k].present;
    assign visited_v[k]  = stat[k].visited;
    assign frontier_v[k] = stat[k].frontier;
  end

  assign marker_out = chain[gcc_pkg::MAX_NODES].valid && chain[gcc_pkg::MAX_NODES].mark;

  // Expand while the frontier is non-empty; finish once it dies out and the
  // result register is free.
  assign search_en = (state == gcc_pkg::ST_SEARCH) && (|frontier_v);
  assign done      = (state == gcc_pkg::ST_SEARCH) && !(|frontier_v) &&
                     (!result.valid || result.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      gcc_pkg::ST_LOAD: begin
        if (accept && edges.last_item) state_next = gcc_pkg::ST_DRAIN;
      end
      gcc_pkg::ST_DRAIN: begin
        if (marker_out) state_next = gcc_pkg::ST_SEARCH;
      end
      gcc_pkg::ST_SEARCH: begin
        if (done) state_next = gcc_pkg::ST_LOAD;
      end
      default: begin
        state_next = gcc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Hold the node count the marker collected on its way down the row.
  always_ff @(posedge clk) begin
    if (marker_out && (state == gcc_pkg::ST_DRAIN)) begin
      count <= chain[gcc_pkg::MAX_NODES].count;
    end
  end

  // Result register: load on done, drop once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result.connected  <= ~(|(present_v & ~visited_v));
      result.node_count <= count;
    end
  end

endmodule

/* src/gcc_cell.sv */
// One node of the graph: its adjacency row, present, visited and frontier flags.
// Passes the chain word on to the next cell every cycle. Depends on gcc_pkg.
module gcc_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [gcc_pkg::NODE_W-1:0]     idx,
  input  gcc_pkg::chain_word_t           word_in,
  output gcc_pkg::chain_word_t           word_out,
  input  logic [gcc_pkg::MAX_NODES-1:0]  frontier_bus,
  input  logic                           search_en,
  input  logic                           clear,
  output gcc_pkg::cell_stat_t            stat
);

  logic [gcc_pkg::MAX_NODES-1:0] row;
  logic                          present;
  logic                          visited;
  logic                          frontier;

  logic a_hit;
  logic b_hit;
  logic present_eff;
  logic seed;
  logic reach;

  assign a_hit       = word_in.valid && word_in.edge_ok && (word_in.node_a == idx);
  assign b_hit       = word_in.valid && word_in.edge_ok && (word_in.node_b == idx);
  assign present_eff = present || a_hit || b_hit;
  assign seed        = word_in.valid && word_in.mark && !word_in.seeded && present_eff;
  assign reach       = |(row & frontier_bus);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row      <= '0;
      present  <= 1'b0;
      visited  <= 1'b0;
      frontier <= 1'b0;
    end else begin
      // Set the far end of the edge in this row; a self loop sets its own bit.
      row <= row | (gcc_pkg::MAX_NODES'(a_hit) << word_in.node_b)
                 | (gcc_pkg::MAX_NODES'(b_hit) << word_in.node_a);
      if (a_hit || b_hit) begin
        present <= 1'b1;
      end
      if (seed) begin
        visited  <= 1'b1;
        frontier <= 1'b1;
      end else if (search_en) begin
        visited  <= visited | reach;
        frontier <= reach & ~visited;
      end
    end
  end

  // Hand the word to the neighbor; the marker picks up this cell's flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else begin
      word_out.valid <= word_in.valid;
    end
    word_out.node_a  <= word_in.node_a;
    word_out.node_b  <= word_in.node_b;
    word_out.edge_ok <= word_in.edge_ok;
    word_out.mark    <= word_in.mark;
    word_out.seeded  <= word_in.seeded || (word_in.mark && present_eff);
    if (word_in.mark && present_eff && (word_in.count != gcc_pkg::COUNT_MAX)) begin
      word_out.count <= word_in.count + gcc_pkg::COUNT_W'(1);
    end else begin
      word_out.count <= word_in.count;
    end
  end

  assign stat.present  = present;
  assign stat.visited  = visited;
  assign stat.frontier = frontier;

endmodule
